/* src/prka_pkg.sv */
// Shared types and constants for the probe resistant key allocation block.
package prka_pkg;

  localparam int MAX_COLUMNS = 64;
  localparam int COL_W = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;

  localparam logic [6:0] ACTIVE_RESET = 7'd64;

  localparam logic [1:0] KIND_ALLOC = 2'd0;
  localparam logic [1:0] KIND_READ  = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;

  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_NO_SLOT = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_SWEEP,
    ST_CLOSE
  } state_e;

  typedef struct packed {
    logic [1:0]  kind;
    logic [63:0] row_bits;
    logic [5:0]  read_column;
    logic [63:0] orig_key0_low;
    logic [63:0] orig_key0_high;
    logic [63:0] orig_key1_low;
    logic [63:0] orig_key1_high;
    logic [63:0] fresh_key_low;
    logic [63:0] fresh_key_high;
  } req_t;

  typedef struct packed {
    logic        status;
    logic [5:0]  closing_column;
    logic [63:0] pair_key0_low;
    logic [63:0] pair_key0_high;
    logic [63:0] pair_key1_low;
    logic [63:0] pair_key1_high;
  } rsp_t;

  typedef struct packed {
    logic [63:0] key0_low;
    logic [63:0] key0_high;
    logic [63:0] key1_low;
    logic [63:0] key1_high;
  } pair_t;

  // Per-cell controls
  typedef struct packed {
    logic clear;
    logic shift;
    logic load;
  } cell_ctl_t;

  // Head unit controls
  typedef struct packed {
    logic init;
    logic step;
    logic share;
    logic capture;
  } head_ctl_t;

endpackage

/* src/prka_cell.sv */
// One column of the key table: holds a key pair and passes it down the ring.
module prka_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  prka_pkg::cell_ctl_t ctl_i,
  input  prka_pkg::pair_t     next_pair_i,
  input  prka_pkg::pair_t     load_pair_i,
  output prka_pkg::pair_t     pair_o,
  output logic                unassigned_o
);

  prka_pkg::pair_t pair_d, pair_q;

  // Pick clear, direct load or shift from the neighbor
  always_comb begin
    pair_d = pair_q;
    priority if (ctl_i.clear) begin
      pair_d = '0;
    end else if (ctl_i.load) begin
      pair_d = load_pair_i;
    end else if (ctl_i.shift) begin
      pair_d = next_pair_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pair_q <= '0;
    end else begin
      pair_q <= pair_d;
    end
  end

  assign pair_o       = pair_q;
  assign unassigned_o = ~|pair_q;

endmodule

/* src/prka_head.sv */
// Ring head: assigns fresh pairs, folds key0 into the accumulator, captures reads.
module prka_head (
  input  logic                clk_i,
  input  prka_pkg::head_ctl_t ctl_i,
  input  prka_pkg::req_t      req_i,
  input  prka_pkg::pair_t     pair_i,
  output prka_pkg::pair_t     pair_o,
  output prka_pkg::pair_t     close_pair_o,
  output prka_pkg::pair_t     read_pair_o
);

  logic [63:0]     delta_low, delta_high;
  logic            unassigned;
  prka_pkg::pair_t fresh_pair;
  logic [63:0]     acc_low_d, acc_low_q, acc_high_d, acc_high_q;
  prka_pkg::pair_t cap_d, cap_q;

  assign delta_low  = req_i.orig_key0_low ^ req_i.orig_key1_low;
  assign delta_high = req_i.orig_key0_high ^ req_i.orig_key1_high;
  assign unassigned = ~|pair_i;

  always_comb begin
    fresh_pair.key0_low  = req_i.fresh_key_low;
    fresh_pair.key0_high = req_i.fresh_key_high;
    fresh_pair.key1_low  = req_i.fresh_key_low ^ delta_low;
    fresh_pair.key1_high = req_i.fresh_key_high ^ delta_high;
  end

  // Give unassigned share columns the fresh pair, pass everything else on
  assign pair_o = (ctl_i.share && unassigned) ? fresh_pair : pair_i;

  // Seed with the original key0, fold in key0 of each non-closing share column
  always_comb begin
    acc_low_d  = acc_low_q;
    acc_high_d = acc_high_q;
    cap_d      = cap_q;
    if (ctl_i.init) begin
      acc_low_d  = req_i.orig_key0_low;
      acc_high_d = req_i.orig_key0_high;
      cap_d      = '0;
    end else if (ctl_i.step) begin
      if (ctl_i.share) begin
        acc_low_d  = acc_low_q ^ pair_o.key0_low;
        acc_high_d = acc_high_q ^ pair_o.key0_high;
      end
      if (ctl_i.capture) begin
        cap_d = pair_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    acc_low_q  <= acc_low_d;
    acc_high_q <= acc_high_d;
    cap_q      <= cap_d;
  end

  always_comb begin
    close_pair_o.key0_low  = acc_low_q;
    close_pair_o.key0_high = acc_high_q;
    close_pair_o.key1_low  = acc_low_q ^ delta_low;
    close_pair_o.key1_high = acc_high_q ^ delta_high;
  end

  assign read_pair_o = cap_q;

endmodule

/* src/probe_resistant_key_allocation_top.sv */
// Top level: key table ring of cells, head unit and request sequencer.
//
// Usage: drive a request on req_i and raise start_i; it is taken at a rising
// edge where start_i is high and busy_o is low. Exactly one result follows on
// rsp_o, valid for the single cycle in which rsp_valid_o is high; the
// receiver must take it then. A new request may be taken while that result
// is still showing.
// Allocate: a search over the per-column free flags, then one full rotation of
// the 64-cell ring through the head unit, then one write of the closing pair;
// the result follows the closing write, or comes straight after the search when
// the row has no free share. Read also makes one full rotation and answers at
// its end; clear and the unused kind answer straight from idle. The next request
// can be taken at the edge that takes the result. The ring length sets the
// length of the rotation.
// The active column count is written over cfg_valid_i/cfg_ready_o/
// cfg_data_i, accepted whenever busy_o is low.
// Reset clears the whole table (every pair unassigned), sets the active
// column count to 64 and leaves the block idle with no result pending.
module probe_resistant_key_allocation_top (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  output logic             busy_o,
  input  prka_pkg::req_t   req_i,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [6:0]       cfg_data_i,
  output logic             rsp_valid_o,
  output prka_pkg::rsp_t   rsp_o
);

  localparam int N = prka_pkg::MAX_COLUMNS;
  localparam int CW = prka_pkg::COL_W;

  prka_pkg::state_e    state_d, state_q;
  prka_pkg::req_t      req_q;
  logic [6:0]          active_q;
  logic [CW-1:0]       cnt_d, cnt_q;
  logic [CW-1:0]       close_d, close_q;
  logic [N-1:0]        row_d, row_q;
  logic                rsp_valid_d, rsp_valid_q;
  prka_pkg::rsp_t      rsp_d, rsp_q;
  logic                accept;
  logic                clear_all;

  prka_pkg::pair_t     cell_pair [N];
  logic [N-1:0]        unassigned;
  prka_pkg::pair_t     head_out, close_pair, read_pair;
  prka_pkg::head_ctl_t head_ctl;

  logic                found;
  logic [CW-1:0]       found_col;

  assign accept      = start_i && (state_q == prka_pkg::ST_IDLE);
  assign busy_o      = (state_q != prka_pkg::ST_IDLE);
  assign cfg_ready_o = (state_q == prka_pkg::ST_IDLE);
  assign clear_all   = accept && (req_i.kind == prka_pkg::KIND_CLEAR);

  // Hold the active column count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= prka_pkg::ACTIVE_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      active_q <= cfg_data_i;
    end
  end

  // Capture the request and its row masked to the active columns
  always_comb begin
    for (int i = 0; i < N; i++) begin
      row_d[i] = req_i.row_bits[i] && (active_q > 7'(i));
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_i;
      row_q <= row_d;
    end
  end

  // Ring of cells: each shifts toward column zero, the head feeds the top cell
  for (genvar g = 0; g < N; g++) begin : g_cell
    prka_pkg::cell_ctl_t ctl;
    prka_pkg::pair_t     next_pair;

    always_comb begin
      ctl.clear = clear_all;
      ctl.shift = (state_q == prka_pkg::ST_SWEEP);
      ctl.load  = (state_q == prka_pkg::ST_CLOSE) && (close_q == CW'(g));
    end

    if (g == N - 1) begin : g_top
      assign next_pair = head_out;
    end else begin : g_mid
      assign next_pair = cell_pair[g + 1];
    end

    prka_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctl_i        (ctl),
      .next_pair_i  (next_pair),
      .load_pair_i  (close_pair),
      .pair_o       (cell_pair[g]),
      .unassigned_o (unassigned[g])
    );
  end

  // Head unit works on the column now sitting in cell zero
  always_comb begin
    head_ctl.init    = (state_q == prka_pkg::ST_SEARCH);
    head_ctl.step    = (state_q == prka_pkg::ST_SWEEP);
    head_ctl.share   = (state_q == prka_pkg::ST_SWEEP) &&
                       (req_q.kind == prka_pkg::KIND_ALLOC) &&
                       row_q[cnt_q] && (cnt_q != close_q);
    head_ctl.capture = (req_q.kind == prka_pkg::KIND_READ) &&
                       (6'(cnt_q) == req_q.read_column);
  end

  prka_head u_head (
    .clk_i        (clk_i),
    .ctl_i        (head_ctl),
    .req_i        (req_q),
    .pair_i       (cell_pair[0]),
    .pair_o       (head_out),
    .close_pair_o (close_pair),
    .read_pair_o  (read_pair)
  );

  // Find the highest free share column
  always_comb begin
    found     = 1'b0;
    found_col = '0;
    for (int i = 0; i < N; i++) begin
      if (row_q[i] && unassigned[i]) begin
        found     = 1'b1;
        found_col = CW'(i);
      end
    end
  end

  // Sequence requests and build results
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    close_d     = close_q;
    rsp_valid_d = 1'b0;
    rsp_d       = rsp_q;
    unique case (state_q)
      prka_pkg::ST_IDLE: begin
        if (start_i) begin
          if ((req_i.kind == prka_pkg::KIND_ALLOC) || (req_i.kind == prka_pkg::KIND_READ)) begin
            state_d = prka_pkg::ST_SEARCH;
          end else begin
            rsp_valid_d = 1'b1;
            rsp_d       = '0;
          end
        end
      end
      prka_pkg::ST_SEARCH: begin
        cnt_d = '0;
        if (req_q.kind == prka_pkg::KIND_READ) begin
          close_d = '0;
          state_d = prka_pkg::ST_SWEEP;
        end else if (found) begin
          close_d = found_col;
          state_d = prka_pkg::ST_SWEEP;
        end else begin
          rsp_valid_d  = 1'b1;
          rsp_d        = '0;
          rsp_d.status = prka_pkg::STATUS_NO_SLOT;
          state_d      = prka_pkg::ST_IDLE;
        end
      end
      prka_pkg::ST_SWEEP: begin
        cnt_d = cnt_q + CW'(1);
        if (cnt_q == CW'(N - 1)) begin
          if (req_q.kind == prka_pkg::KIND_READ) begin
            state_d = prka_pkg::ST_IDLE;
          end else begin
            state_d = prka_pkg::ST_CLOSE;
          end
        end
      end
      prka_pkg::ST_CLOSE: begin
        state_d = prka_pkg::ST_IDLE;
      end
      default: begin
        state_d = prka_pkg::ST_IDLE;
      end
    endcase

    // Results that leave straight from the sweep or the closing write
    if ((state_q == prka_pkg::ST_SWEEP) && (cnt_q == CW'(N - 1)) &&
        (req_q.kind == prka_pkg::KIND_READ)) begin
      rsp_valid_d          = 1'b1;
      rsp_d.status         = prka_pkg::STATUS_OK;
      rsp_d.closing_column = req_q.read_column;
      rsp_d.pair_key0_low  = head_ctl.capture ? cell_pair[0].key0_low  : read_pair.key0_low;
      rsp_d.pair_key0_high = head_ctl.capture ? cell_pair[0].key0_high : read_pair.key0_high;
      rsp_d.pair_key1_low  = head_ctl.capture ? cell_pair[0].key1_low  : read_pair.key1_low;
      rsp_d.pair_key1_high = head_ctl.capture ? cell_pair[0].key1_high : read_pair.key1_high;
    end
    if (state_q == prka_pkg::ST_CLOSE) begin
      rsp_valid_d          = 1'b1;
      rsp_d.status         = prka_pkg::STATUS_OK;
      rsp_d.closing_column = 6'(close_q);
      rsp_d.pair_key0_low  = close_pair.key0_low;
      rsp_d.pair_key0_high = close_pair.key0_high;
      rsp_d.pair_key1_low  = close_pair.key1_low;
      rsp_d.pair_key1_high = close_pair.key1_high;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= prka_pkg::ST_IDLE;
      cnt_q       <= '0;
      close_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      close_q     <= close_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

endmodule

/* test/tb_probe_resistant_key_allocation_top.sv */
// Self-checking testbench for the probe resistant key allocation block.
`timescale 1ns / 100ps

module tb_probe_resistant_key_allocation_top;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int TAIL_CYCLES = 70;
  localparam int WATCHDOG_LIMIT = 2000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b1;
  logic start_i = 1'b0;
  logic busy_o;
  prka_pkg::req_t req_i = '0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [6:0] cfg_data_i = '0;
  logic rsp_valid_o;
  prka_pkg::rsp_t rsp_o;

  // Predictor state: the key pair table and the active column count
  prka_pkg::pair_t key_table [prka_pkg::MAX_COLUMNS];
  logic [6:0] active_cols_model = prka_pkg::ACTIVE_RESET;
  prka_pkg::rsp_t pair_report_q [$];
  prka_pkg::rsp_t want_rsp;

  int error_count = 0;
  int n_alloc = 0;
  int n_read = 0;
  int n_clear = 0;
  int n_unused = 0;
  int n_no_slot = 0;
  int n_checked = 0;
  int n_cfg = 0;
  int quiet_cycles = 0;

  probe_resistant_key_allocation_top i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .req_i      (req_i),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .rsp_valid_o(rsp_valid_o),
    .rsp_o      (rsp_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic bit column_free(int c);
    return key_table[c] == '0;
  endfunction

  // Update the table for one request and return the result it must produce
  function automatic prka_pkg::rsp_t apply_key_request(prka_pkg::req_t r);
    prka_pkg::rsp_t rsp;
    int unsigned cols;
    logic [63:0] row, mask, acc_low, acc_high, d_low, d_high;
    int close;
    bit found;
    rsp = '0;
    close = 0;
    found = 1'b0;
    case (r.kind)
      prka_pkg::KIND_ALLOC: begin
        cols = (active_cols_model > prka_pkg::MAX_COLUMNS) ? prka_pkg::MAX_COLUMNS :
               active_cols_model;
        mask = (cols >= 64) ? '1 : ((64'd1 << cols) - 64'd1);
        row = r.row_bits & mask;
        d_low = r.orig_key0_low ^ r.orig_key1_low;
        d_high = r.orig_key0_high ^ r.orig_key1_high;
        // closing column: highest share that is still unassigned
        for (int j = 0; j < prka_pkg::MAX_COLUMNS; j++) begin
          if (row[j] && column_free(j)) begin
            found = 1'b1;
            close = j;
          end
        end
        if (!found) begin
          rsp.status = prka_pkg::STATUS_NO_SLOT;
        end else begin
          acc_low = r.orig_key0_low;
          acc_high = r.orig_key0_high;
          for (int j = 0; j < prka_pkg::MAX_COLUMNS; j++) begin
            if (row[j] && j != close) begin
              if (column_free(j)) begin
                key_table[j].key0_low = r.fresh_key_low;
                key_table[j].key0_high = r.fresh_key_high;
                key_table[j].key1_low = r.fresh_key_low ^ d_low;
                key_table[j].key1_high = r.fresh_key_high ^ d_high;
              end
              acc_low ^= key_table[j].key0_low;
              acc_high ^= key_table[j].key0_high;
            end
          end
          key_table[close].key0_low = acc_low;
          key_table[close].key0_high = acc_high;
          key_table[close].key1_low = acc_low ^ d_low;
          key_table[close].key1_high = acc_high ^ d_high;
          rsp.status = prka_pkg::STATUS_OK;
          rsp.closing_column = close[5:0];
          rsp.pair_key0_low = acc_low;
          rsp.pair_key0_high = acc_high;
          rsp.pair_key1_low = acc_low ^ d_low;
          rsp.pair_key1_high = acc_high ^ d_high;
        end
      end
      prka_pkg::KIND_READ: begin
        rsp.closing_column = r.read_column;
        rsp.pair_key0_low = key_table[r.read_column].key0_low;
        rsp.pair_key0_high = key_table[r.read_column].key0_high;
        rsp.pair_key1_low = key_table[r.read_column].key1_low;
        rsp.pair_key1_high = key_table[r.read_column].key1_high;
      end
      prka_pkg::KIND_CLEAR: begin
        for (int j = 0; j < prka_pkg::MAX_COLUMNS; j++) key_table[j] = '0;
      end
      default: ;
    endcase
    return rsp;
  endfunction

  function automatic logic [63:0] pick_key();
    case ($urandom_range(0, 15))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Mostly sparse rows inside the active columns so allocations keep succeeding
  function automatic logic [63:0] pick_row();
    logic [63:0] row;
    int unsigned top;
    row = '0;
    top = (active_cols_model == 0) ? 0 :
          (active_cols_model > prka_pkg::MAX_COLUMNS) ? prka_pkg::MAX_COLUMNS - 1 :
          active_cols_model - 1;
    case ($urandom_range(0, 11))
      0: row = '0;
      1: row = '1;
      2: row = {$urandom, $urandom};
      3: row = {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
      default: begin
        for (int i = $urandom_range(1, 4); i > 0; i--) begin
          if ($urandom_range(0, 4) == 0) row[$urandom_range(0, 63)] = 1'b1;
          else row[$urandom_range(0, top)] = 1'b1;
        end
      end
    endcase
    return row;
  endfunction

  function automatic prka_pkg::req_t random_req();
    prka_pkg::req_t r;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) r.kind = prka_pkg::KIND_ALLOC;
    else if (pick < 88) r.kind = prka_pkg::KIND_READ;
    else if (pick < 95) r.kind = prka_pkg::KIND_CLEAR;
    else r.kind = KIND_UNUSED;
    r.row_bits = pick_row();
    r.read_column = $urandom_range(0, 3) == 0 ? 6'($urandom_range(0, 63)) :
                    6'($urandom_range(0, (active_cols_model > 1 &&
                       active_cols_model <= prka_pkg::MAX_COLUMNS) ?
                       active_cols_model - 1 : 63));
    r.orig_key0_low = pick_key();
    r.orig_key0_high = pick_key();
    r.orig_key1_low = pick_key();
    r.orig_key1_high = pick_key();
    // sometimes a zero delta, sometimes a zero fresh key
    if ($urandom_range(0, 7) == 0) begin
      r.orig_key1_low = r.orig_key0_low;
      r.orig_key1_high = r.orig_key0_high;
    end
    r.fresh_key_low = pick_key();
    r.fresh_key_high = pick_key();
    if ($urandom_range(0, 9) == 0) begin
      r.fresh_key_low = '0;
      r.fresh_key_high = '0;
    end
    return r;
  endfunction

  // Present one request, hold it until taken, and queue its expected result
  task automatic send_request(input prka_pkg::req_t r);
    prka_pkg::rsp_t rsp;
    @(negedge clk_i);
    start_i <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    rsp = apply_key_request(r);
    pair_report_q.push_back(rsp);
    case (r.kind)
      prka_pkg::KIND_ALLOC: begin
        n_alloc++;
        if (rsp.status == prka_pkg::STATUS_NO_SLOT) n_no_slot++;
      end
      prka_pkg::KIND_READ: n_read++;
      prka_pkg::KIND_CLEAR: n_clear++;
      default: n_unused++;
    endcase
  endtask

  task automatic send_shaped(input logic [1:0] kind, input logic [63:0] row,
                             input logic [5:0] col);
    prka_pkg::req_t r;
    r = random_req();
    r.kind = kind;
    r.row_bits = row;
    r.read_column = col;
    send_request(r);
  endtask

  task automatic idle_cycles(input int n);
    repeat (n) begin
      @(negedge clk_i);
      start_i <= 1'b0;
    end
  endtask

  // Drop start, wait for every queued result, then let the block settle
  task automatic wait_all_reported(input int tail);
    @(negedge clk_i);
    start_i <= 1'b0;
    while (pair_report_q.size() != 0) @(posedge clk_i);
    repeat (tail) @(posedge clk_i);
  endtask

  task automatic write_active_columns(input logic [6:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= value;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    active_cols_model = value;
    n_cfg++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %h, got %h", name, want, got);
      error_count++;
    end
  endtask

  // Compare each result against the oldest outstanding request
  always @(posedge clk_i) begin
    if (rst_ni && rsp_valid_o === 1'b1) begin
      if (pair_report_q.size() == 0) begin
        $error("result with no request outstanding, closing_column %0d",
               rsp_o.closing_column);
        error_count++;
      end else begin
        want_rsp = pair_report_q.pop_front();
        n_checked++;
        check_field("status", want_rsp.status, rsp_o.status);
        check_field("closing_column", want_rsp.closing_column, rsp_o.closing_column);
        check_field("pair_key0_low", want_rsp.pair_key0_low, rsp_o.pair_key0_low);
        check_field("pair_key0_high", want_rsp.pair_key0_high, rsp_o.pair_key0_high);
        check_field("pair_key1_low", want_rsp.pair_key1_low, rsp_o.pair_key1_low);
        check_field("pair_key1_high", want_rsp.pair_key1_high, rsp_o.pair_key1_high);
      end
    end
  end

  // Abort when no handshake of any kind happens for too long
  initial begin
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if (rst_ni && ((start_i && busy_o === 1'b0) || rsp_valid_o === 1'b1 ||
                     (cfg_valid_i && cfg_ready_o === 1'b1)))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
    $display("end of test: mismatches");
    $finish;
  end

  // Every kind, key extremes, full and empty rows, zero pairs
  task automatic test_directed_basics();
    prka_pkg::req_t r;
    send_shaped(prka_pkg::KIND_READ, '0, 6'd0);
    send_shaped(prka_pkg::KIND_READ, '1, 6'd63);
    send_shaped(prka_pkg::KIND_ALLOC, '0, 6'd0);
    r = random_req();
    r.kind = prka_pkg::KIND_ALLOC;
    r.row_bits = '1;
    r.orig_key0_low = '1;
    r.orig_key0_high = '1;
    r.orig_key1_low = '0;
    r.orig_key1_high = '1;
    r.fresh_key_low = '1;
    r.fresh_key_high = '1;
    send_request(r);
    send_shaped(prka_pkg::KIND_ALLOC, '1, 6'd0);
    send_shaped(prka_pkg::KIND_READ, '0, 6'd63);
    send_shaped(prka_pkg::KIND_READ, '0, 6'd0);
    send_shaped(prka_pkg::KIND_CLEAR, '1, 6'd63);
    send_shaped(KIND_UNUSED, '1, 6'd63);
    send_shaped(prka_pkg::KIND_READ, '0, 6'd5);
    // closing pair of all zeros leaves the column unassigned
    r = random_req();
    r.kind = prka_pkg::KIND_ALLOC;
    r.row_bits = 64'h1;
    r.orig_key0_low = '0;
    r.orig_key0_high = '0;
    r.orig_key1_low = '0;
    r.orig_key1_high = '0;
    send_request(r);
    send_request(r);
    // fresh pair of all zeros with a zero delta
    r = random_req();
    r.kind = prka_pkg::KIND_ALLOC;
    r.row_bits = 64'h3;
    r.orig_key1_low = r.orig_key0_low;
    r.orig_key1_high = r.orig_key0_high;
    r.fresh_key_low = '0;
    r.fresh_key_high = '0;
    send_request(r);
    send_shaped(prka_pkg::KIND_READ, '0, 6'd0);
    send_shaped(prka_pkg::KIND_ALLOC, 64'h6, 6'd0);
    send_shaped(prka_pkg::KIND_READ, '0, 6'd2);
    send_shaped(prka_pkg::KIND_CLEAR, '0, 6'd0);
    wait_all_reported(TAIL_CYCLES);
  endtask

  // Column count extremes: none in use, one, and an oversized value
  task automatic test_column_limits();
    write_active_columns(7'd0);
    send_shaped(prka_pkg::KIND_ALLOC, '1, 6'd0);
    send_shaped(prka_pkg::KIND_READ, '1, 6'd10);
    wait_all_reported(TAIL_CYCLES);
    write_active_columns(7'd1);
    send_shaped(prka_pkg::KIND_ALLOC, '1, 6'd0);
    send_shaped(prka_pkg::KIND_ALLOC, 64'h2, 6'd0);
    send_shaped(prka_pkg::KIND_ALLOC, 64'h1, 6'd0);
    wait_all_reported(TAIL_CYCLES);
    write_active_columns(7'd127);
    send_shaped(prka_pkg::KIND_ALLOC, '1, 6'd0);
    wait_all_reported(TAIL_CYCLES);
  endtask

  // Random requests in bursts under one column count
  task automatic run_traffic_phase(input int n);
    int sent;
    int burst;
    prka_pkg::req_t r;
    sent = 0;
    while (sent < n) begin
      burst = $urandom_range(1, 12);
      for (int i = 0; i < burst && sent < n; i++) begin
        r = random_req();
        send_request(r);
        if (r.kind != KIND_UNUSED) sent++;
      end
      case ($urandom_range(0, 9))
        0, 1, 2: ;
        3: wait_all_reported(0);
        default: idle_cycles($urandom_range(1, 90));
      endcase
    end
  endtask

  task automatic test_random_traffic();
    logic [6:0] setting;
    for (int p = 0; p < 8; p++) begin
      case (p)
        0: setting = 7'd64;
        1: setting = 7'd1;
        2: setting = 7'd2;
        3: setting = 7'd63;
        4: setting = 7'd127;
        5: setting = 7'd0;
        6: setting = 7'($urandom_range(3, 62));
        default: setting = 7'($urandom_range(65, 127));
      endcase
      write_active_columns(setting);
      run_traffic_phase(setting == 7'd0 ? 60 : 170);
      wait_all_reported(TAIL_CYCLES);
    end
  endtask

  initial begin
    for (int j = 0; j < prka_pkg::MAX_COLUMNS; j++) key_table[j] = '0;
    // Assert reset after time zero so the asynchronous reset sees the edge
    #1;
    rst_ni = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed_basics();
    test_column_limits();
    test_random_traffic();
    wait_all_reported(TAIL_CYCLES);

    if (pair_report_q.size() != 0) begin
      $error("%0d results never arrived", pair_report_q.size());
      error_count++;
    end
    $display("covered %0d requests: %0d allocate (%0d without a free share), %0d read, %0d unused",
             n_alloc + n_read + n_clear + n_unused, n_alloc, n_no_slot, n_read,
             n_unused);
    $display("also %0d table clears, %0d column count writes, %0d results checked",
             n_clear, n_cfg, n_checked);
    if (error_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
